### rtl/bchj_pkg.sv
// ----------------------------------------------------------------------------
// bchj_pkg: shared types and constants for the bucket-chained hash join table
// Table sizes, derived widths, word structs, controller states, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bchj_pkg;

  localparam int HEAD_BUCKETS     = 1024;
  localparam int SLOTS_PER_BUCKET = 2;
  localparam int POOL_BUCKETS     = 1024;

  localparam int BKT_W  = (HEAD_BUCKETS > 1) ? $clog2(HEAD_BUCKETS) : 1;
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int LINK_W = $clog2(POOL_BUCKETS + 1);
  localparam int POOL_W = (POOL_BUCKETS > 1) ? $clog2(POOL_BUCKETS) : 1;
  localparam int META_W = FILL_W + LINK_W;
  localparam int HK_DEPTH = HEAD_BUCKETS * SLOTS_PER_BUCKET;
  localparam int SK_DEPTH = POOL_BUCKETS * SLOTS_PER_BUCKET;
  localparam int HK_AW  = $clog2(HK_DEPTH);
  localparam int SK_AW  = $clog2(SK_DEPTH);

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 32;
  localparam int MASK_W  = 10;
  localparam int SKIP_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MASK_W;

  localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(63);
  localparam logic [SKIP_W-1:0] SKIP_RESET = '0;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SHIFT = CFG_IDX_W'(1);

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] match_total;
    logic               pool_full;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_SMETA_B,
    ST_ALLOC,
    ST_HKEY,
    ST_SMETA_P,
    ST_SKEY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic head_append;
    logic sm_rd;
    logic sm_from_spill;
    logic spill_append;
    logic alloc;
    logic hk_rd;
    logic sk_rd;
    logic slot_next;
    logic finish;
    logic fin_hit;
    logic fin_full;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mode;
    logic h_room;
    logic h_empty;
    logic h_link_nz;
    logic s_room;
    logic s_empty;
    logic s_link_nz;
    logic hk_eq;
    logic sk_eq;
    logic h_more;
    logic s_more;
    logic pool_empty;
    logic out_free;
  } status_t;

endpackage

### rtl/bchj_ram.sv
// ----------------------------------------------------------------------------
// bchj_ram: generic single-write, single-read memory
// One write port and one read port with registered read data that holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module bchj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bchj_ctrl.sv
// ----------------------------------------------------------------------------
// bchj_ctrl: sequencer for build and probe operations
// Walks the clearing pass, head bucket, overflow chain and result hand-off,
// issuing one command group per cycle to the datapath.
// ----------------------------------------------------------------------------
module bchj_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bchj_pkg::status_t st,
  output bchj_pkg::cmd_t    cmd
);

  bchj_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bchj_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != bchj_pkg::ST_IDLE);
    unique case (state)
      bchj_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_done) begin
          state_next = bchj_pkg::ST_IDLE;
        end
      end
      bchj_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = bchj_pkg::ST_META;
        end
      end
      bchj_pkg::ST_META: begin
        if (st.mode == bchj_pkg::MODE_BUILD) begin
          if (st.h_room) begin
            cmd.head_append = 1'b1;
            cmd.finish      = 1'b1;
            state_next      = bchj_pkg::ST_DONE;
          end else if (st.h_link_nz) begin
            cmd.sm_rd  = 1'b1;
            state_next = bchj_pkg::ST_SMETA_B;
          end else begin
            state_next = bchj_pkg::ST_ALLOC;
          end
        end else begin
          if (!st.h_empty) begin
            cmd.hk_rd  = 1'b1;
            state_next = bchj_pkg::ST_HKEY;
          end else if (st.h_link_nz) begin
            cmd.sm_rd  = 1'b1;
            state_next = bchj_pkg::ST_SMETA_P;
          end else begin
            cmd.finish = 1'b1;
            state_next = bchj_pkg::ST_DONE;
          end
        end
      end
      bchj_pkg::ST_SMETA_B: begin
        if (st.s_room) begin
          cmd.spill_append = 1'b1;
          cmd.finish       = 1'b1;
          state_next       = bchj_pkg::ST_DONE;
        end else begin
          state_next = bchj_pkg::ST_ALLOC;
        end
      end
      bchj_pkg::ST_ALLOC: begin
        cmd.finish = 1'b1;
        if (st.pool_empty) begin
          cmd.fin_full = 1'b1;
        end else begin
          cmd.alloc = 1'b1;
        end
        state_next = bchj_pkg::ST_DONE;
      end
      bchj_pkg::ST_HKEY: begin
        if (st.hk_eq) begin
          cmd.finish  = 1'b1;
          cmd.fin_hit = 1'b1;
          state_next  = bchj_pkg::ST_DONE;
        end else if (st.h_more) begin
          cmd.hk_rd     = 1'b1;
          cmd.slot_next = 1'b1;
        end else if (st.h_link_nz) begin
          cmd.sm_rd  = 1'b1;
          state_next = bchj_pkg::ST_SMETA_P;
        end else begin
          cmd.finish = 1'b1;
          state_next = bchj_pkg::ST_DONE;
        end
      end
      bchj_pkg::ST_SMETA_P: begin
        if (!st.s_empty) begin
          cmd.sk_rd  = 1'b1;
          state_next = bchj_pkg::ST_SKEY;
        end else if (st.s_link_nz) begin
          cmd.sm_rd         = 1'b1;
          cmd.sm_from_spill = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = bchj_pkg::ST_DONE;
        end
      end
      bchj_pkg::ST_SKEY: begin
        if (st.sk_eq) begin
          cmd.finish  = 1'b1;
          cmd.fin_hit = 1'b1;
          state_next  = bchj_pkg::ST_DONE;
        end else if (st.s_more) begin
          cmd.sk_rd     = 1'b1;
          cmd.slot_next = 1'b1;
        end else if (st.s_link_nz) begin
          cmd.sm_rd         = 1'b1;
          cmd.sm_from_spill = 1'b1;
          state_next        = bchj_pkg::ST_SMETA_P;
        end else begin
          cmd.finish = 1'b1;
          state_next = bchj_pkg::ST_DONE;
        end
      end
      bchj_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bchj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bchj_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/bchj_dp.sv
// ----------------------------------------------------------------------------
// bchj_dp: table memories, configuration and result register
// Holds the head and pool bucket stores, the chain pointer, slot counter,
// pool allocation count, hit counter and the output word register.
// ----------------------------------------------------------------------------
module bchj_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bchj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bchj_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  bchj_pkg::in_t                      in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bchj_pkg::out_t                     out_word,
  input  bchj_pkg::cmd_t                     cmd,
  output bchj_pkg::status_t                  st
);

  localparam int FW = bchj_pkg::FILL_W;
  localparam int LW = bchj_pkg::LINK_W;
  localparam int PW = bchj_pkg::POOL_W;
  localparam int BW = bchj_pkg::BKT_W;
  localparam int SW = bchj_pkg::SLOT_W;
  localparam int KW = bchj_pkg::KEY_W;
  localparam int CW = bchj_pkg::COUNT_W;
  localparam int MW = bchj_pkg::META_W;

  logic [bchj_pkg::MASK_W-1:0] key_mask;
  logic [bchj_pkg::SKIP_W-1:0] idx_shift;
  logic                        mode_r;
  logic [KW-1:0]               key_r;
  logic [BW-1:0]               bucket_r;
  logic [BW-1:0]               clr_cnt;
  logic [LW-1:0]               link_r;
  logic [SW-1:0]               slot_r;
  logic [LW-1:0]               spill_used;
  logic [CW-1:0]               hit_count;
  logic                        pend_hit;
  logic                        pend_full;

  logic [BW-1:0] bucket_in;
  logic [KW-1:0] masked;
  logic [SW-1:0] slot_rd;
  logic [LW-1:0] link_sel;
  logic [PW-1:0] link_idx;
  logic [CW-1:0] hit_count_next;

  logic [MW-1:0] hm_rdata, sm_rdata;
  logic [FW-1:0] hfill, sfill;
  logic [LW-1:0] hlink, slink;
  logic [KW-1:0] hk_rdata, sk_rdata;

  logic                      hm_we;
  logic [BW-1:0]             hm_waddr;
  logic [MW-1:0]             hm_wdata;
  logic                      hk_we;
  logic [bchj_pkg::HK_AW-1:0] hk_waddr, hk_raddr;
  logic                      sm_we;
  logic [PW-1:0]             sm_waddr, sm_raddr;
  logic [MW-1:0]             sm_wdata;
  logic                      sk_we;
  logic [bchj_pkg::SK_AW-1:0] sk_waddr, sk_raddr;

  assign masked    = in_word.key & KW'(key_mask);
  assign bucket_in = BW'(masked >> idx_shift);

  assign {hfill, hlink} = hm_rdata;
  assign {sfill, slink} = sm_rdata;

  assign slot_rd  = cmd.slot_next ? SW'(slot_r + SW'(1)) : '0;
  assign link_sel = cmd.sm_from_spill ? slink : hlink;
  assign link_idx = PW'(link_r - LW'(1));

  always_comb begin
    hm_we    = cmd.clear | cmd.head_append | cmd.alloc;
    hm_waddr = cmd.clear ? clr_cnt : bucket_r;
    if (cmd.clear) begin
      hm_wdata = '0;
    end else if (cmd.head_append) begin
      hm_wdata = {FW'(hfill + FW'(1)), hlink};
    end else begin
      hm_wdata = {hfill, LW'(spill_used + LW'(1))};
    end

    hk_we    = cmd.head_append;
    hk_waddr = bchj_pkg::HK_AW'(32'(bucket_r) * bchj_pkg::SLOTS_PER_BUCKET + 32'(hfill));
    hk_raddr = bchj_pkg::HK_AW'(32'(bucket_r) * bchj_pkg::SLOTS_PER_BUCKET + 32'(slot_rd));

    sm_we    = cmd.spill_append | cmd.alloc;
    sm_waddr = cmd.alloc ? PW'(spill_used) : link_idx;
    sm_wdata = cmd.alloc ? {FW'(1), hlink} : {FW'(sfill + FW'(1)), slink};
    sm_raddr = PW'(link_sel - LW'(1));

    sk_we    = cmd.spill_append | cmd.alloc;
    sk_waddr = cmd.alloc ?
               bchj_pkg::SK_AW'(32'(spill_used) * bchj_pkg::SLOTS_PER_BUCKET) :
               bchj_pkg::SK_AW'(32'(link_idx) * bchj_pkg::SLOTS_PER_BUCKET + 32'(sfill));
    sk_raddr = bchj_pkg::SK_AW'(32'(link_idx) * bchj_pkg::SLOTS_PER_BUCKET + 32'(slot_rd));
  end

  bchj_ram #(.WIDTH(MW), .DEPTH(bchj_pkg::HEAD_BUCKETS)) u_head_meta (
    .clk   (clk),
    .we    (hm_we),
    .waddr (hm_waddr),
    .wdata (hm_wdata),
    .re    (cmd.accept),
    .raddr (bucket_in),
    .rdata (hm_rdata)
  );

  bchj_ram #(.WIDTH(KW), .DEPTH(bchj_pkg::HK_DEPTH)) u_head_keys (
    .clk   (clk),
    .we    (hk_we),
    .waddr (hk_waddr),
    .wdata (key_r),
    .re    (cmd.hk_rd),
    .raddr (hk_raddr),
    .rdata (hk_rdata)
  );

  bchj_ram #(.WIDTH(MW), .DEPTH(bchj_pkg::POOL_BUCKETS)) u_spill_meta (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (cmd.sm_rd),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  bchj_ram #(.WIDTH(KW), .DEPTH(bchj_pkg::SK_DEPTH)) u_spill_keys (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (key_r),
    .re    (cmd.sk_rd),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  assign hit_count_next = (pend_hit && (hit_count != {CW{1'b1}})) ?
                          CW'(hit_count + CW'(1)) : hit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask   <= bchj_pkg::MASK_RESET;
      idx_shift  <= bchj_pkg::SKIP_RESET;
      clr_cnt    <= '0;
      spill_used <= '0;
      hit_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bchj_pkg::REG_KEY_MASK:  key_mask  <= cfg_data[bchj_pkg::MASK_W-1:0];
          bchj_pkg::REG_IDX_SHIFT: idx_shift <= cfg_data[bchj_pkg::SKIP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_cnt <= BW'(clr_cnt + BW'(1));
      end
      if (cmd.alloc) begin
        spill_used <= LW'(spill_used + LW'(1));
      end
      if (cmd.out_load) begin
        hit_count <= hit_count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_word.mode;
      key_r    <= in_word.key;
      bucket_r <= bucket_in;
    end
    if (cmd.sm_rd) begin
      link_r <= link_sel;
    end
    if (cmd.hk_rd || cmd.sk_rd) begin
      slot_r <= slot_rd;
    end
    if (cmd.finish) begin
      pend_hit  <= cmd.fin_hit;
      pend_full <= cmd.fin_full;
    end
    if (cmd.out_load) begin
      out_word.hit         <= pend_hit;
      out_word.match_total <= hit_count_next;
      out_word.pool_full   <= pend_full;
    end
  end

  always_comb begin
    st.clr_done   = (clr_cnt == BW'(bchj_pkg::HEAD_BUCKETS - 1));
    st.mode       = mode_r;
    st.h_room     = (32'(hfill) < bchj_pkg::SLOTS_PER_BUCKET);
    st.h_empty    = (hfill == '0);
    st.h_link_nz  = (hlink != '0);
    st.s_room     = (32'(sfill) < bchj_pkg::SLOTS_PER_BUCKET);
    st.s_empty    = (sfill == '0);
    st.s_link_nz  = (slink != '0);
    st.hk_eq      = (hk_rdata == key_r);
    st.sk_eq      = (sk_rdata == key_r);
    st.h_more     = ((32'(slot_r) + 1) < 32'(hfill));
    st.s_more     = ((32'(slot_r) + 1) < 32'(sfill));
    st.pool_empty = (32'(spill_used) >= bchj_pkg::POOL_BUCKETS);
    st.out_free   = !out_valid || !out_stall;
  end

  a_no_hit_and_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.hit && out_word.pool_full))
    else $error("hit and pool_full raised together");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> (32'(spill_used) < bchj_pkg::POOL_BUCKETS))
    else $error("pool bucket allocated beyond pool size");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (hit_count >= $past(hit_count)))
    else $error("match count went backwards");

  a_build_no_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && mode_r == bchj_pkg::MODE_BUILD) |-> !cmd.fin_hit)
    else $error("build reported a hit");

endmodule

### rtl/bucket_chained_hash_join_table.sv
// ----------------------------------------------------------------------------
// bucket_chained_hash_join_table: build/probe hash join table
// Each input word builds or probes one 32-bit key. Each word returns one
// output word with the probe hit flag, the running hit count and the
// pool exhaustion flag.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall/in_word and results leave on
// out_valid/out_stall/out_word. The bucket index is (key & mask) >> shift,
// with mask and shift set through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, and the block itself does not enforce this.
// After reset the block runs a clearing pass over all HEAD_BUCKETS (1024)
// head buckets, one bucket per cycle, with in_stall high. One word is
// worked on at a time through a single read port per table. A build reads
// the head bucket's fill and link, then appends the key to the head bucket
// or to its first overflow bucket, or allocates a pool bucket if one is free.
// A probe compares the head slots in turn, then walks the overflow chain
// through pool memory, reading each bucket's metadata and then its slots.
// The next word is accepted in the idle state once the result is in the
// output register, even while the receiver stalls it. If the receiver still
// stalls when the following result is ready, the block waits in its
// final state with in_stall high until the output register frees.
// ----------------------------------------------------------------------------
module bucket_chained_hash_join_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bchj_pkg::in_t                   in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bchj_pkg::out_t                  out_word,
  input  logic                            cfg_we,
  input  logic [bchj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bchj_pkg::CFG_DATA_W-1:0] cfg_data
);

  bchj_pkg::cmd_t    cmd;
  bchj_pkg::status_t st;

  bchj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bchj_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
